// ===== hw/rtl/todhue_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the time-of-day hue interpolator.
// Holds the breakpoint table, field widths and the segment descriptor.
// No dependencies.
package todhue_pkg;

  // Field widths
  localparam int IN_W      = 18;  // signed seconds at the input
  localparam int OUT_W     = 17;  // hue in fixed point at the output
  localparam int SEC_W     = 17;  // seconds within one day, 0..86399
  localparam int OFF_W     = 14;  // offset within one segment, up to three hours
  localparam int DELTA_W   = 8;   // hue step magnitude, up to 180 degrees
  localparam int DEG_W     = 9;   // whole degrees, 0..359
  localparam int SEG_IDX_W = 4;

  localparam int HUE_FRAC_BITS_DEF = 8;
  localparam int DAY_SEC           = 86400;
  localparam int HOUR_SEC          = 3600;
  localparam int TURN_DEG          = 360;

  // Breakpoints: twelve stops bound eleven segments
  localparam int SEG_COUNT  = 11;
  localparam int STOP_COUNT = SEG_COUNT + 1;

  localparam int STOP_SEC [STOP_COUNT] = '{
    0 * HOUR_SEC,  3 * HOUR_SEC,  5 * HOUR_SEC,  6 * HOUR_SEC,
    8 * HOUR_SEC,  10 * HOUR_SEC, 12 * HOUR_SEC, 15 * HOUR_SEC,
    17 * HOUR_SEC, 19 * HOUR_SEC, 21 * HOUR_SEC, DAY_SEC
  };

  localparam int STOP_DEG [STOP_COUNT] = '{
    250, 270, 310, 340, 40, 70, 120, 185, 215, 245, 270, 250
  };

  // Shortest signed hue step of each segment (a step of exactly 180 counts as +180)
  localparam int SEG_DELTA [SEG_COUNT] = '{
    20, 40, 30, 60, 30, 50, 65, 30, 30, 25, -20
  };

  // Segment length, selects the constant divisor downstream
  typedef enum logic [1:0] {
    SPAN_1H = 2'd0,
    SPAN_2H = 2'd1,
    SPAN_3H = 2'd2
  } span_e;

  // One segment lookup, already turned into an upward step from base
  typedef struct packed {
    logic [DEG_W-1:0]   base;
    logic [DELTA_W-1:0] delta;
    logic [OFF_W-1:0]   off;
    span_e              span;
  } seg_t;

endpackage

// ===== hw/rtl/todhue_seg.sv =====
`timescale 1ns / 1ps
// Segment lookup for the time-of-day hue interpolator.
// Finds the segment holding a second of the day and builds its step descriptor.
// Depends on todhue_pkg.
module todhue_seg
  import todhue_pkg::*;
(
  input  logic [SEC_W-1:0] sec_i,
  output seg_t             seg_o
);

  logic [SEG_IDX_W-1:0] idx;

  // Earliest segment whose end is at or after the time: a breakpoint takes the earlier one
  always_comb begin
    idx = SEG_IDX_W'(SEG_COUNT - 1);
    for (int i = SEG_COUNT - 1; i >= 0; i--) begin
      if (sec_i <= SEC_W'(STOP_SEC[i+1])) begin
        idx = SEG_IDX_W'(i);
      end
    end
  end

  // Falling segments are walked backwards from their end hue, so every step is upward
  always_comb begin
    seg_o = '0;
    for (int i = 0; i < SEG_COUNT; i++) begin
      if (idx == SEG_IDX_W'(i)) begin
        if (SEG_DELTA[i] < 0) begin
          seg_o.base  = DEG_W'(STOP_DEG[i+1]);
          seg_o.delta = DELTA_W'(-SEG_DELTA[i]);
          seg_o.off   = OFF_W'(SEC_W'(STOP_SEC[i+1]) - sec_i);
        end else begin
          seg_o.base  = DEG_W'(STOP_DEG[i]);
          seg_o.delta = DELTA_W'(SEG_DELTA[i]);
          seg_o.off   = OFF_W'(sec_i - SEC_W'(STOP_SEC[i]));
        end
        case (STOP_SEC[i+1] - STOP_SEC[i])
          HOUR_SEC:     seg_o.span = SPAN_1H;
          2 * HOUR_SEC: seg_o.span = SPAN_2H;
          default:      seg_o.span = SPAN_3H;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/time_of_day_hue_interpolator.sv =====
`timescale 1ns / 1ps
// Time-of-day hue interpolator: seven-stage pipeline, one transaction per cycle
// unless the output stalls; a new item may enter every cycle unless every stage is
// full and the output is stalled. Depth is set by the two constant-reciprocal
// divisions, each a multiply followed by its own register. Stages with no item fill
// while the output is stalled. Reset clears the stage valid bits only.
module time_of_day_hue_interpolator
  import todhue_pkg::*;
#(
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [IN_W-1:0] time_seconds_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_W-1:0]       hue_fixed_o
);

  localparam int STAGES = 7;

  // First division: p / span, p below 2^P_W
  localparam int P_W     = OFF_W + DELTA_W - 1;
  localparam int DIV_W   = OFF_W;
  localparam int K1      = P_W + DIV_W;
  localparam int M1_W    = P_W + 3;
  localparam int PROD1_W = P_W + M1_W;
  // Second division: (remainder << frac) / span
  localparam int N2_W    = DIV_W + HUE_FRAC_BITS;
  localparam int K2      = N2_W + DIV_W;
  localparam int M2_W    = HUE_FRAC_BITS + 17;
  localparam int PROD2_W = N2_W + M2_W;
  localparam int HUE_FW  = DEG_W + HUE_FRAC_BITS;

  localparam logic [63:0] D1 = 64'(HOUR_SEC);
  localparam logic [63:0] D2 = 64'(2 * HOUR_SEC);
  localparam logic [63:0] D3 = 64'(3 * HOUR_SEC);

  localparam logic [M1_W-1:0] M1_1H = M1_W'(((64'd1 << K1) + D1 - 64'd1) / D1);
  localparam logic [M1_W-1:0] M1_2H = M1_W'(((64'd1 << K1) + D2 - 64'd1) / D2);
  localparam logic [M1_W-1:0] M1_3H = M1_W'(((64'd1 << K1) + D3 - 64'd1) / D3);
  localparam logic [M2_W-1:0] M2_1H = M2_W'(((64'd1 << K2) + D1 - 64'd1) / D1);
  localparam logic [M2_W-1:0] M2_2H = M2_W'(((64'd1 << K2) + D2 - 64'd1) / D2);
  localparam logic [M2_W-1:0] M2_3H = M2_W'(((64'd1 << K2) + D3 - 64'd1) / D3);

  localparam logic signed [19:0] DAY_S  = 20'sd86400;
  localparam logic [HUE_FW-1:0]  TURN_F = HUE_FW'(TURN_DEG) << HUE_FRAC_BITS;

  // Stage valid bits and advance enables
  logic [STAGES-1:0] valid_q;
  logic [STAGES:0]   en;

  always_comb begin
    en[STAGES] = out_ready_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 0: fold the signed time into one day
  logic signed [19:0] t_ext;
  logic [SEC_W-1:0]   sec_d, sec_q;

  always_comb begin
    t_ext = 20'(time_seconds_i);
    if (t_ext < -DAY_S) begin
      sec_d = SEC_W'(t_ext + (DAY_S <<< 1));
    end else if (t_ext < 20'sd0) begin
      sec_d = SEC_W'(t_ext + DAY_S);
    end else if (t_ext >= DAY_S) begin
      sec_d = SEC_W'(t_ext - DAY_S);
    end else begin
      sec_d = SEC_W'(t_ext);
    end
  end

  // Stage 1: segment lookup
  seg_t seg_d, seg_q;

  todhue_seg u_seg (
    .sec_i (sec_q),
    .seg_o (seg_d)
  );

  // Stage 2: step times offset
  logic [P_W-1:0]   p_d, p2_q;
  logic [DEG_W-1:0] base2_q;
  span_e            span2_q;

  assign p_d = P_W'({{(P_W-DELTA_W){1'b0}}, seg_q.delta} * {{(P_W-OFF_W){1'b0}}, seg_q.off});

  // Stage 3: whole degrees of the step via reciprocal multiply
  logic [M1_W-1:0]    m1_sel;
  logic [PROD1_W-1:0] prod1_d, prod1_q;
  logic [P_W-1:0]     p3_q;
  logic [DEG_W-1:0]   base3_q;
  span_e              span3_q;

  always_comb begin
    case (span2_q)
      SPAN_1H: m1_sel = M1_1H;
      SPAN_2H: m1_sel = M1_2H;
      SPAN_3H: m1_sel = M1_3H;
      default: m1_sel = M1_3H;
    endcase
  end

  assign prod1_d = PROD1_W'(p2_q) * PROD1_W'(m1_sel);

  // Stage 4: remainder and wrapped whole hue
  logic [DELTA_W-1:0] q1;
  logic [DIV_W-1:0]   div3;
  logic [DIV_W-1:0]   r_d, r4_q;
  logic [DEG_W:0]     hsum;
  logic [DEG_W-1:0]   hint_d, hint4_q;
  span_e              span4_q;

  assign q1 = prod1_q[K1 +: DELTA_W];

  always_comb begin
    case (span3_q)
      SPAN_1H: div3 = DIV_W'(D1);
      SPAN_2H: div3 = DIV_W'(D2);
      SPAN_3H: div3 = DIV_W'(D3);
      default: div3 = DIV_W'(D3);
    endcase
  end

  always_comb begin
    r_d  = DIV_W'(p3_q - P_W'(P_W'(q1) * P_W'(div3)));
    hsum = (DEG_W+1)'(base3_q) + (DEG_W+1)'(q1);
    if (hsum >= (DEG_W+1)'(TURN_DEG)) begin
      hint_d = DEG_W'(hsum - (DEG_W+1)'(TURN_DEG));
    end else begin
      hint_d = DEG_W'(hsum);
    end
  end

  // Stage 5: fraction bits via second reciprocal multiply
  logic [M2_W-1:0]    m2_sel;
  logic [PROD2_W-1:0] prod2_d, prod2_q;
  logic [DEG_W-1:0]   hint5_q;

  always_comb begin
    case (span4_q)
      SPAN_1H: m2_sel = M2_1H;
      SPAN_2H: m2_sel = M2_2H;
      SPAN_3H: m2_sel = M2_3H;
      default: m2_sel = M2_3H;
    endcase
  end

  assign prod2_d = PROD2_W'(N2_W'(r4_q) << HUE_FRAC_BITS) * PROD2_W'(m2_sel);

  // Stage 6: result register
  logic [HUE_FW-1:0] hue_d, hue_q;

  assign hue_d = (HUE_FW'(hint5_q) << HUE_FRAC_BITS) | HUE_FW'(prod2_q >> K2);

  assign hue_fixed_o = OUT_W'(hue_q);

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sec_q <= sec_d;
    end
    if (en[1]) begin
      seg_q <= seg_d;
    end
    if (en[2]) begin
      p2_q    <= p_d;
      base2_q <= seg_q.base;
      span2_q <= seg_q.span;
    end
    if (en[3]) begin
      prod1_q <= prod1_d;
      p3_q    <= p2_q;
      base3_q <= base2_q;
      span3_q <= span2_q;
    end
    if (en[4]) begin
      r4_q    <= r_d;
      hint4_q <= hint_d;
      span4_q <= span3_q;
    end
    if (en[5]) begin
      prod2_q <= prod2_d;
      hint5_q <= hint4_q;
    end
    if (en[6]) begin
      hue_q <= hue_d;
    end
  end

  // Checks
  a_sec_in_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> sec_q < SEC_W'(DAY_SEC))
    else $error("folded time outside one day");

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] |-> r4_q < (span4_q == SPAN_1H ? DIV_W'(D1) :
                           span4_q == SPAN_2H ? DIV_W'(D2) : DIV_W'(D3)))
    else $error("division remainder not below divisor");

  a_hue_below_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hue_q < TURN_F)
    else $error("hue not wrapped below a full turn");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q && !out_ready_i))
    else $error("input stalled with a free stage");

endmodule
